@@ sv/alpha_rect_blitter_defines.svh @@
// ============================================================================
// alpha_rect_blitter_defines.svh
// Assertion macros shared by the checking code of the blitter.
// ============================================================================
`ifndef ALPHA_RECT_BLITTER_DEFINES_SVH
`define ALPHA_RECT_BLITTER_DEFINES_SVH

// Same-cycle implication, switched off while reset is held.
`define ARB_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define ARB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/arb_pkg.sv @@
// ============================================================================
// arb_pkg
// Shared constants, types and helpers of the alpha rectangle blitter.
// ============================================================================
package arb_pkg;

    localparam int SCREEN_WIDTH  = 256;
    localparam int SCREEN_HEIGHT = 256;
    localparam int PIXEL_COUNT   = SCREEN_WIDTH * SCREEN_HEIGHT;

    localparam int ADDR_W  = $clog2(PIXEL_COUNT);
    localparam int COL_W   = $clog2(SCREEN_WIDTH);
    localparam int ROW_W   = $clog2(SCREEN_HEIGHT);
    localparam int OP_W    = 2;
    localparam int COORD_W = 16;
    localparam int POS_W   = COORD_W + 2;
    localparam int PIXEL_W = 24;
    localparam int CHAN_W  = 8;
    localparam int ALPHA_W = 17;
    localparam int FRAC_W  = 16;
    localparam int PROD_W  = CHAN_W + ALPHA_W;
    localparam int WORD_W  = 32;

    localparam logic [ALPHA_W-1:0]       ALPHA_ONE   = ALPHA_W'(32'h10000);
    localparam logic [ALPHA_W-1:0]       ALPHA_RESET = ALPHA_W'(53248);
    localparam logic [PIXEL_W-1:0]       WHITE       = 24'hFFFFFF;
    localparam logic [CHAN_W-1:0]        WORD_TOP    = 8'hFF;
    localparam logic signed [POS_W-1:0]  SW_POS      = POS_W'(SCREEN_WIDTH);
    localparam logic signed [POS_W-1:0]  SH_POS      = POS_W'(SCREEN_HEIGHT);
    localparam logic signed [POS_W-1:0]  POS_ONE     = POS_W'(1);

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR = 2'd0,
        OP_BOX   = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_CLEAR,
        ST_BOX,
        ST_DRAIN,
        ST_READ_WAIT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } t_rd_req;

    typedef struct packed {
        logic               en;
        logic [ADDR_W-1:0]  addr;
        logic [PIXEL_W-1:0] data;
    } t_wr_req;

    typedef struct packed {
        logic [ALPHA_W-1:0] alpha;
        logic [CHAN_W-1:0]  add_r;
        logic [CHAN_W-1:0]  add_g;
        logic [CHAN_W-1:0]  add_b;
    } t_blend_terms;

    typedef struct packed {
        logic [WORD_W-1:0] pixel_word;
        logic              status;
    } t_result;

    // Linear framebuffer address of a pixel, rows stored one after another.
    function automatic logic [ADDR_W-1:0] pixel_addr(input logic [ROW_W-1:0] row,
                                                     input logic [COL_W-1:0] col);
        return ADDR_W'(ADDR_W'(row) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(col));
    endfunction

endpackage

@@ sv/arb_if.sv @@
// ============================================================================
// arb_if
// Valid/ready channels of the blitter: command, configuration and result.
// ============================================================================
interface arb_cmd_if;
    logic                                  valid;
    logic                                  ready;
    logic [arb_pkg::OP_W-1:0]              operation;
    logic signed [arb_pkg::COORD_W-1:0]    x_pos;
    logic signed [arb_pkg::COORD_W-1:0]    y_pos;
    logic signed [arb_pkg::COORD_W-1:0]    box_width;
    logic signed [arb_pkg::COORD_W-1:0]    box_height;
    logic [arb_pkg::PIXEL_W-1:0]           box_color;

    modport source (output valid, operation, x_pos, y_pos, box_width, box_height,
                    box_color, input ready);
    modport sink   (input valid, operation, x_pos, y_pos, box_width, box_height,
                    box_color, output ready);
endinterface

interface arb_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [arb_pkg::ALPHA_W-1:0]   blend_alpha;

    modport source (output valid, blend_alpha, input ready);
    modport sink   (input valid, blend_alpha, output ready);
endinterface

interface arb_res_if;
    logic                          valid;
    logic                          ready;
    logic [arb_pkg::WORD_W-1:0]    pixel_word;
    logic                          status;

    modport source (output valid, pixel_word, status, input ready);
    modport sink   (input valid, pixel_word, status, output ready);
endinterface

@@ sv/arb_frame_ram.sv @@
// ============================================================================
// arb_frame_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ============================================================================
module arb_frame_ram #(
    parameter int DEPTH  = 65536,
    parameter int DATA_W = 24
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [DATA_W-1:0]        i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [DATA_W-1:0]        o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

@@ sv/arb_blend.sv @@
// ============================================================================
// arb_blend
// Per-channel blend stage: scales the old pixel and adds the colour term.
// ============================================================================
module arb_blend (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  arb_pkg::t_rd_req               i_pix,
    input  logic [arb_pkg::PIXEL_W-1:0]    i_old,
    input  arb_pkg::t_blend_terms          i_terms,
    output arb_pkg::t_wr_req               o_wr
);

    localparam int CW = arb_pkg::CHAN_W;
    localparam int FW = arb_pkg::FRAC_W;
    localparam int PW = arb_pkg::PROD_W;

    logic [PW-1:0]              prod_r, prod_g, prod_b;
    logic                       r_valid;
    logic [arb_pkg::ADDR_W-1:0] r_addr;
    logic [CW-1:0]              r_keep_r, r_keep_g, r_keep_b;

    // The product never reaches bit 24, so the scaled channel is its middle byte.
    assign prod_r = PW'(i_old[2*CW +: CW]) * PW'(i_terms.alpha);
    assign prod_g = PW'(i_old[CW +: CW])   * PW'(i_terms.alpha);
    assign prod_b = PW'(i_old[0 +: CW])    * PW'(i_terms.alpha);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_pix.en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr   <= i_pix.addr;
        r_keep_r <= prod_r[FW +: CW];
        r_keep_g <= prod_g[FW +: CW];
        r_keep_b <= prod_b[FW +: CW];
    end

    // Channel sums wrap to eight bits.
    assign o_wr.en   = r_valid;
    assign o_wr.addr = r_addr;
    assign o_wr.data = {CW'(r_keep_r + i_terms.add_r),
                        CW'(r_keep_g + i_terms.add_g),
                        CW'(r_keep_b + i_terms.add_b)};

endmodule

@@ sv/arb_ctrl.sv @@
// ============================================================================
// arb_ctrl
// Command sequencer: clipping, address walk, read-back and result forming.
// ============================================================================
module arb_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    arb_cmd_if.sink                       i_cmd,
    input  logic [arb_pkg::ALPHA_W-1:0]   i_alpha,
    input  logic [arb_pkg::PIXEL_W-1:0]   i_rd_data,
    input  logic                          i_blend_busy,
    input  logic                          i_res_taken,
    output arb_pkg::t_rd_req              o_rd,
    output arb_pkg::t_rd_req              o_blend_pix,
    output arb_pkg::t_wr_req              o_clr_wr,
    output arb_pkg::t_blend_terms         o_terms,
    output logic                          o_res_valid,
    output arb_pkg::t_result              o_result
);

    localparam int CW = arb_pkg::CHAN_W;
    localparam int FW = arb_pkg::FRAC_W;
    localparam int PW = arb_pkg::PROD_W;
    localparam int AW = arb_pkg::ADDR_W;
    localparam int PS = arb_pkg::POS_W;
    localparam int CD = arb_pkg::COORD_W;

    arb_pkg::t_state r_state, n_state;
    logic            r_p1_valid, n_p1_valid;
    logic [AW-1:0]   r_p1_addr, n_p1_addr;

    arb_pkg::t_op                     r_op, n_op;
    logic signed [CD-1:0]             r_x, n_x, r_y, n_y, r_w, n_w, r_h, n_h;
    logic [arb_pkg::PIXEL_W-1:0]      r_color, n_color;
    logic [AW-1:0]                    r_addr, n_addr, r_row_base, n_row_base;
    logic [arb_pkg::COL_W-1:0]        r_col, n_col, r_col_first, n_col_first;
    logic [arb_pkg::COL_W-1:0]        r_col_last, n_col_last;
    logic [arb_pkg::ROW_W-1:0]        r_row, n_row, r_row_last, n_row_last;
    arb_pkg::t_blend_terms            r_terms, n_terms;
    arb_pkg::t_result                 r_result, n_result;

    logic signed [PS-1:0] x_s, y_s, x_end, y_end, x_lo, y_lo, x_hi, y_hi;
    logic signed [PS-1:0] x_last, y_last;
    logic                 box_empty, read_off;
    logic [arb_pkg::ALPHA_W-1:0] alpha_sat, keep;
    logic [PW-1:0]        cprod_r, cprod_g, cprod_b;
    logic [AW-1:0]        box_start;

    // Clipping of the box to the screen, in widened signed arithmetic.
    always_comb begin
        x_s    = {{(PS-CD){r_x[CD-1]}}, r_x};
        y_s    = {{(PS-CD){r_y[CD-1]}}, r_y};
        x_end  = x_s + {{(PS-CD){r_w[CD-1]}}, r_w};
        y_end  = y_s + {{(PS-CD){r_h[CD-1]}}, r_h};
        x_lo   = x_s[PS-1] ? '0 : x_s;
        y_lo   = y_s[PS-1] ? '0 : y_s;
        x_hi   = (x_end > arb_pkg::SW_POS) ? arb_pkg::SW_POS : x_end;
        y_hi   = (y_end > arb_pkg::SH_POS) ? arb_pkg::SH_POS : y_end;
        x_last = x_hi - arb_pkg::POS_ONE;
        y_last = y_hi - arb_pkg::POS_ONE;
        box_empty = (x_hi <= x_lo) || (y_hi <= y_lo);
        read_off  = x_s[PS-1] || y_s[PS-1] ||
                    (x_s >= arb_pkg::SW_POS) || (y_s >= arb_pkg::SH_POS);
        box_start = arb_pkg::pixel_addr(y_lo[arb_pkg::ROW_W-1:0],
                                        x_lo[arb_pkg::COL_W-1:0]);
    end

    // Colour terms of the blend, fixed for the whole box.
    always_comb begin
        alpha_sat = (i_alpha > arb_pkg::ALPHA_ONE) ? arb_pkg::ALPHA_ONE : i_alpha;
        keep      = arb_pkg::ALPHA_ONE - alpha_sat;
        cprod_r   = PW'(r_color[2*CW +: CW]) * PW'(keep);
        cprod_g   = PW'(r_color[CW +: CW])   * PW'(keep);
        cprod_b   = PW'(r_color[0 +: CW])    * PW'(keep);
    end

    always_comb begin
        n_state     = r_state;
        n_p1_valid  = 1'b0;
        n_p1_addr   = r_addr;
        n_op        = r_op;
        n_x         = r_x;
        n_y         = r_y;
        n_w         = r_w;
        n_h         = r_h;
        n_color     = r_color;
        n_addr      = r_addr;
        n_row_base  = r_row_base;
        n_col       = r_col;
        n_col_first = r_col_first;
        n_col_last  = r_col_last;
        n_row       = r_row;
        n_row_last  = r_row_last;
        n_terms     = r_terms;
        n_result    = r_result;
        i_cmd.ready = 1'b0;
        o_rd        = '0;
        o_clr_wr    = '0;
        o_res_valid = 1'b0;

        case (r_state)
            arb_pkg::ST_IDLE: begin
                i_cmd.ready = 1'b1;
                if (i_cmd.valid) begin
                    n_op    = arb_pkg::t_op'(i_cmd.operation);
                    n_x     = i_cmd.x_pos;
                    n_y     = i_cmd.y_pos;
                    n_w     = i_cmd.box_width;
                    n_h     = i_cmd.box_height;
                    n_color = i_cmd.box_color;
                    n_state = arb_pkg::ST_SETUP;
                end
            end
            arb_pkg::ST_SETUP: begin
                n_terms.alpha = alpha_sat;
                n_terms.add_r = cprod_r[FW +: CW];
                n_terms.add_g = cprod_g[FW +: CW];
                n_terms.add_b = cprod_b[FW +: CW];
                n_result      = '0;
                case (r_op)
                    arb_pkg::OP_CLEAR: begin
                        n_addr  = '0;
                        n_state = arb_pkg::ST_CLEAR;
                    end
                    arb_pkg::OP_BOX: begin
                        if (box_empty) begin
                            n_state = arb_pkg::ST_DONE;
                        end else begin
                            n_col       = x_lo[arb_pkg::COL_W-1:0];
                            n_col_first = x_lo[arb_pkg::COL_W-1:0];
                            n_col_last  = x_last[arb_pkg::COL_W-1:0];
                            n_row       = y_lo[arb_pkg::ROW_W-1:0];
                            n_row_last  = y_last[arb_pkg::ROW_W-1:0];
                            n_addr      = box_start;
                            n_row_base  = box_start;
                            n_state     = arb_pkg::ST_BOX;
                        end
                    end
                    arb_pkg::OP_READ: begin
                        if (read_off) begin
                            n_result.status = 1'b1;
                            n_state         = arb_pkg::ST_DONE;
                        end else begin
                            o_rd.en   = 1'b1;
                            o_rd.addr = arb_pkg::pixel_addr(y_s[arb_pkg::ROW_W-1:0],
                                                            x_s[arb_pkg::COL_W-1:0]);
                            n_state   = arb_pkg::ST_READ_WAIT;
                        end
                    end
                    default: begin
                        n_state = arb_pkg::ST_DONE;
                    end
                endcase
            end
            arb_pkg::ST_CLEAR: begin
                o_clr_wr.en   = 1'b1;
                o_clr_wr.addr = r_addr;
                o_clr_wr.data = arb_pkg::WHITE;
                if (r_addr == AW'(arb_pkg::PIXEL_COUNT - 1)) begin
                    n_state = arb_pkg::ST_DONE;
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
            arb_pkg::ST_BOX: begin
                o_rd.en    = 1'b1;
                o_rd.addr  = r_addr;
                n_p1_valid = 1'b1;
                n_p1_addr  = r_addr;
                if (r_col == r_col_last) begin
                    if (r_row == r_row_last) begin
                        n_state = arb_pkg::ST_DRAIN;
                    end else begin
                        n_row      = r_row + arb_pkg::ROW_W'(1);
                        n_col      = r_col_first;
                        n_row_base = r_row_base + AW'(arb_pkg::SCREEN_WIDTH);
                        n_addr     = r_row_base + AW'(arb_pkg::SCREEN_WIDTH);
                    end
                end else begin
                    n_col  = r_col + arb_pkg::COL_W'(1);
                    n_addr = r_addr + AW'(1);
                end
            end
            arb_pkg::ST_DRAIN: begin
                if (!r_p1_valid && !i_blend_busy) begin
                    n_state = arb_pkg::ST_DONE;
                end
            end
            arb_pkg::ST_READ_WAIT: begin
                n_result.pixel_word = {arb_pkg::WORD_TOP, i_rd_data};
                n_result.status     = 1'b0;
                n_state             = arb_pkg::ST_DONE;
            end
            arb_pkg::ST_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_taken) begin
                    n_state = arb_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = arb_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= arb_pkg::ST_IDLE;
            r_p1_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_p1_valid <= n_p1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1_addr   <= n_p1_addr;
        r_op        <= n_op;
        r_x         <= n_x;
        r_y         <= n_y;
        r_w         <= n_w;
        r_h         <= n_h;
        r_color     <= n_color;
        r_addr      <= n_addr;
        r_row_base  <= n_row_base;
        r_col       <= n_col;
        r_col_first <= n_col_first;
        r_col_last  <= n_col_last;
        r_row       <= n_row;
        r_row_last  <= n_row_last;
        r_terms     <= n_terms;
        r_result    <= n_result;
    end

    assign o_blend_pix.en   = r_p1_valid;
    assign o_blend_pix.addr = r_p1_addr;
    assign o_terms          = r_terms;
    assign o_result         = r_result;

endmodule

@@ sv/alpha_rect_blitter.sv @@
// ============================================================================
// alpha_rect_blitter
// 2D blitter with clear, alpha-blended box fill and pixel read-back.
// ============================================================================
// The block owns a framebuffer of SCREEN_WIDTH by SCREEN_HEIGHT 24-bit pixels
// in one synchronous RAM and takes one command word at a time. Clear writes
// white to every pixel. Box clips the rectangle to the screen and
// read-modify-writes each covered pixel, one pixel per cycle through the RAM's
// single write port. Every command gives one result word; the output register
// lets the next command be accepted while that word waits to be taken, and the
// command is finished when its result enters that register. The framebuffer
// is not initialised by reset: issue a clear before any box or read. The
// alpha register may be written only while no command is in progress.
module alpha_rect_blitter (
    input  logic      i_clk,
    input  logic      i_rst_n,
    arb_cmd_if.sink   i_cmd,
    arb_cfg_if.sink   i_cfg,
    arb_res_if.source o_res
);

    // Blend weight kept from the old pixel; saturation happens at box set-up.
    logic [arb_pkg::ALPHA_W-1:0] r_alpha;

    // Result output register.
    logic                        r_out_valid;
    logic [arb_pkg::WORD_W-1:0]  r_out_word;
    logic                        r_out_status;
    logic                        slot_free;

    arb_pkg::t_rd_req      rd_req;
    arb_pkg::t_rd_req      blend_pix;
    arb_pkg::t_wr_req      clr_wr;
    arb_pkg::t_wr_req      blend_wr;
    arb_pkg::t_wr_req      ram_wr;
    arb_pkg::t_blend_terms terms;
    arb_pkg::t_result      result;
    logic                  res_valid;
    logic [arb_pkg::PIXEL_W-1:0] rd_data;

    // Configuration writes are always taken.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= arb_pkg::ALPHA_RESET;
        end else if (i_cfg.valid) begin
            r_alpha <= i_cfg.blend_alpha;
        end
    end

    arb_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (i_cmd),
        .i_alpha      (r_alpha),
        .i_rd_data    (rd_data),
        .i_blend_busy (blend_wr.en),
        .i_res_taken  (slot_free),
        .o_rd         (rd_req),
        .o_blend_pix  (blend_pix),
        .o_clr_wr     (clr_wr),
        .o_terms      (terms),
        .o_res_valid  (res_valid),
        .o_result     (result)
    );

    arb_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (blend_pix),
        .i_old   (rd_data),
        .i_terms (terms),
        .o_wr    (blend_wr)
    );

    // Clear and blend write-back never run together, so a plain select does.
    assign ram_wr = blend_wr.en ? blend_wr : clr_wr;

    arb_frame_ram #(
        .DEPTH  (arb_pkg::PIXEL_COUNT),
        .DATA_W (arb_pkg::PIXEL_W)
    ) u_frame_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr.en),
        .i_wr_addr (ram_wr.addr),
        .i_wr_data (ram_wr.data),
        .i_rd_en   (rd_req.en),
        .i_rd_addr (rd_req.addr),
        .o_rd_data (rd_data)
    );

    // The output register takes a new word when it is empty or being emptied.
    assign slot_free = !r_out_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (slot_free) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (slot_free && res_valid) begin
            r_out_word   <= result.pixel_word;
            r_out_status <= result.status;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.pixel_word = r_out_word;
    assign o_res.status     = r_out_status;

endmodule

@@ sv/arb_checker.sv @@
// ============================================================================
// arb_checker
// Port-level checks of the blitter, bound to the top level.
// ============================================================================
`include "alpha_rect_blitter_defines.svh"

module arb_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_cmd_valid,
    input logic                        i_cmd_ready,
    input logic                        i_res_valid,
    input logic                        i_res_ready,
    input logic [arb_pkg::WORD_W-1:0]  i_res_pixel_word,
    input logic                        i_res_status
);

    // A stalled result word keeps its value.
    `ARB_ASSERT_NEXT(a_res_hold, i_clk, i_rst_n, i_res_valid && !i_res_ready, i_res_valid && $stable(i_res_pixel_word) && $stable(i_res_status), "result word changed while stalled")

    // The block works on one command at a time.
    `ARB_ASSERT_NEXT(a_busy_after_cmd, i_clk, i_rst_n, i_cmd_valid && i_cmd_ready, !i_cmd_ready, "command taken while another is in progress")

    // An off-screen read returns a zero word.
    `ARB_ASSERT_SAME(a_off_screen_zero, i_clk, i_rst_n, i_res_valid && i_res_status, i_res_pixel_word == '0, "off-screen read returned pixel data")

    // A pixel word always carries the fixed top byte.
    `ARB_ASSERT_SAME(a_word_marker, i_clk, i_rst_n, i_res_valid && (i_res_pixel_word != '0), i_res_pixel_word[arb_pkg::WORD_W-1 -: arb_pkg::CHAN_W] == arb_pkg::WORD_TOP, "pixel word without top marker")

endmodule

bind alpha_rect_blitter arb_checker u_arb_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_cmd_valid      (i_cmd.valid),
    .i_cmd_ready      (i_cmd.ready),
    .i_res_valid      (o_res.valid),
    .i_res_ready      (o_res.ready),
    .i_res_pixel_word (o_res.pixel_word),
    .i_res_status     (o_res.status)
);

@@ dv/tb.sv @@
`timescale 1ns / 100ps
// ============================================================================
// tb
// Self-checking bench for the alpha rectangle blitter.
// ============================================================================
// A directed table comes first: the clear, reads at the screen corners and
// off the screen, the unused operation, and boxes that are clipped, wholly
// off the screen or empty, at the blend weights zero, one and above one.
// Random commands follow in four phases, each at its own blend weight. Every
// accepted command word is run through a local model of the framebuffer, and
// each result word is checked against the oldest prediction. The command
// sender idles in bursts and the result taker stalls on a changing pattern.
// ============================================================================
module tb;

    // The limit leaves a wide margin over the slowest correct run, whose time
    // goes mostly to clears and full-screen boxes.
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int LONG_HOLD    = 400;
    localparam int END_QUIET    = 32;
    localparam int PHASES       = 4;
    localparam int PHASE_ITEMS  = 25;
    localparam int NOISE_AREA   = 4096;
    localparam int REPORT_LIMIT = 10;

    localparam int SW  = arb_pkg::SCREEN_WIDTH;
    localparam int SH  = arb_pkg::SCREEN_HEIGHT;
    localparam int CRD = arb_pkg::COORD_W;
    localparam int PXW = arb_pkg::PIXEL_W;
    localparam int ALW = arb_pkg::ALPHA_W;

    typedef enum logic {ROW_CMD, ROW_CFG} t_row_kind;

    typedef struct {
        arb_pkg::t_op          op;
        logic signed [CRD-1:0] x_pos;
        logic signed [CRD-1:0] y_pos;
        logic signed [CRD-1:0] box_width;
        logic signed [CRD-1:0] box_height;
        logic [PXW-1:0]        box_color;
    } t_blit_cmd;

    typedef struct {
        t_row_kind        kind;
        t_blit_cmd        cmd;
        logic [ALW-1:0]   alpha;
        bit               typed;
        arb_pkg::t_result want;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    arb_cmd_if cmd_ch ();
    arb_cfg_if cfg_ch ();
    arb_res_if res_ch ();

    alpha_rect_blitter u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .i_cfg   (cfg_ch),
        .o_res   (res_ch)
    );

    // Local copy of the framebuffer and of the blend weight register.
    logic [PXW-1:0] frame_model [arb_pkg::PIXEL_COUNT];
    logic [ALW-1:0] alpha_model;

    // Result words predicted for accepted commands, oldest first.
    arb_pkg::t_result pending_results [$];
    t_stim_row        stim_rows [$];

    int mismatches    = 0;
    int results_seen  = 0;
    int clears_sent   = 0;
    int boxes_sent    = 0;
    int reads_sent    = 0;
    int others_sent   = 0;
    int burst_left    = 0;
    int holds_asked   = 0;
    int holds_granted = 0;
    int cycle_count   = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Prediction. Applies one command to the local framebuffer and returns
    // the result word that the block should give for it.
    // ------------------------------------------------------------------------
    function automatic arb_pkg::t_result predict_blit(input t_blit_cmd c);
        arb_pkg::t_result res;
        int               x0, y0, x1, y1, row, col, i;
        int unsigned      a, keep, add_r, add_g, add_b, nr, ng, nb;
        logic [PXW-1:0]   p;
        res = '0;
        case (c.op)
            arb_pkg::OP_CLEAR: begin
                for (i = 0; i < arb_pkg::PIXEL_COUNT; i++) frame_model[i] = arb_pkg::WHITE;
            end
            arb_pkg::OP_BOX: begin
                // A weight above one saturates, which keeps the old pixel.
                a     = (alpha_model > arb_pkg::ALPHA_ONE) ? 32'h10000 : int'(alpha_model);
                keep  = 32'h10000 - a;
                add_r = (int'(c.box_color[23:16]) * keep) >> arb_pkg::FRAC_W;
                add_g = (int'(c.box_color[15:8])  * keep) >> arb_pkg::FRAC_W;
                add_b = (int'(c.box_color[7:0])   * keep) >> arb_pkg::FRAC_W;
                x0 = (int'(c.x_pos) < 0) ? 0 : int'(c.x_pos);
                y0 = (int'(c.y_pos) < 0) ? 0 : int'(c.y_pos);
                x1 = int'(c.x_pos) + int'(c.box_width);
                y1 = int'(c.y_pos) + int'(c.box_height);
                if (x1 > SW) x1 = SW;
                if (y1 > SH) y1 = SH;
                for (row = y0; row < y1; row++) begin
                    for (col = x0; col < x1; col++) begin
                        p  = frame_model[row * SW + col];
                        nr = (((int'(p[23:16]) * a) >> arb_pkg::FRAC_W) + add_r) & 32'hFF;
                        ng = (((int'(p[15:8])  * a) >> arb_pkg::FRAC_W) + add_g) & 32'hFF;
                        nb = (((int'(p[7:0])   * a) >> arb_pkg::FRAC_W) + add_b) & 32'hFF;
                        frame_model[row * SW + col] = {nr[7:0], ng[7:0], nb[7:0]};
                    end
                end
            end
            arb_pkg::OP_READ: begin
                if (c.x_pos < 0 || c.y_pos < 0 || int'(c.x_pos) >= SW ||
                    int'(c.y_pos) >= SH) begin
                    res.status = 1'b1;
                end else begin
                    res.pixel_word = {arb_pkg::WORD_TOP,
                                      frame_model[int'(c.y_pos) * SW + int'(c.x_pos)]};
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus builders.
    // ------------------------------------------------------------------------
    function automatic t_stim_row cmd_row(input arb_pkg::t_op op, input int x, input int y,
                                          input int w, input int h,
                                          input logic [PXW-1:0] colour,
                                          input bit typed,
                                          input logic [arb_pkg::WORD_W-1:0] word,
                                          input logic status);
        t_stim_row r;
        r.kind                = ROW_CMD;
        r.cmd.op              = op;
        r.cmd.x_pos           = CRD'(x);
        r.cmd.y_pos           = CRD'(y);
        r.cmd.box_width       = CRD'(w);
        r.cmd.box_height      = CRD'(h);
        r.cmd.box_color       = colour;
        r.alpha               = '0;
        r.typed               = typed;
        r.want.pixel_word     = word;
        r.want.status         = status;
        return r;
    endfunction

    function automatic t_stim_row cfg_row(input logic [ALW-1:0] value);
        t_stim_row r;
        r       = cmd_row(arb_pkg::OP_NONE, 0, 0, 0, 0, '0, 1'b0, '0, 1'b0);
        r.kind  = ROW_CFG;
        r.alpha = value;
        return r;
    endfunction

    // Random command. Most are small well-formed boxes and reads on or just off
    // the screen; the rest are full-range noise, with noise boxes kept to a modest area.
    function automatic t_blit_cmd random_cmd();
        t_blit_cmd c;
        int        pick, tries, wx, hy, area;
        pick        = $urandom_range(0, 99);
        c.box_color = PXW'($urandom);
        if (pick < 45) begin
            c.op         = arb_pkg::OP_BOX;
            c.x_pos      = CRD'(int'($urandom_range(0, 271)) - 8);
            c.y_pos      = CRD'(int'($urandom_range(0, 271)) - 8);
            c.box_width  = CRD'($urandom_range(1, 32));
            c.box_height = CRD'($urandom_range(1, 32));
        end else if (pick < 85) begin
            c.op         = arb_pkg::OP_READ;
            c.x_pos      = CRD'(int'($urandom_range(0, 257)) - 1);
            c.y_pos      = CRD'(int'($urandom_range(0, 257)) - 1);
            c.box_width  = CRD'($urandom);
            c.box_height = CRD'($urandom);
        end else if (pick < 90) begin
            c.op         = arb_pkg::OP_NONE;
            c.x_pos      = CRD'($urandom);
            c.y_pos      = CRD'($urandom);
            c.box_width  = CRD'($urandom);
            c.box_height = CRD'($urandom);
        end else begin
            c.op  = arb_pkg::t_op'(arb_pkg::OP_W'($urandom_range(arb_pkg::OP_BOX,
                                                                 arb_pkg::OP_READ)));
            tries = 0;
            do begin
                c.x_pos      = CRD'($urandom);
                c.y_pos      = CRD'($urandom);
                c.box_width  = CRD'($urandom);
                c.box_height = CRD'($urandom);
                wx = int'(c.x_pos) + int'(c.box_width);
                hy = int'(c.y_pos) + int'(c.box_height);
                wx = ((wx > SW) ? SW : wx) - ((c.x_pos < 0) ? 0 : int'(c.x_pos));
                hy = ((hy > SH) ? SH : hy) - ((c.y_pos < 0) ? 0 : int'(c.y_pos));
                area = (wx > 0 && hy > 0) ? wx * hy : 0;
                tries++;
            end while (c.op == arb_pkg::OP_BOX && area > NOISE_AREA && tries < 50);
            if (c.op == arb_pkg::OP_BOX && area > NOISE_AREA) c.box_height = '0;
        end
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // Command sender. Called just after a falling edge. Words go out in
    // bursts; valid stays high from one word to the next inside a burst.
    // ------------------------------------------------------------------------
    task automatic issue_cmd(input t_blit_cmd c, input bit typed,
                             input arb_pkg::t_result want);
        arb_pkg::t_result predicted;
        int               gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                cmd_ch.valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        cmd_ch.operation  = c.op;
        cmd_ch.x_pos      = c.x_pos;
        cmd_ch.y_pos      = c.y_pos;
        cmd_ch.box_width  = c.box_width;
        cmd_ch.box_height = c.box_height;
        cmd_ch.box_color  = c.box_color;
        cmd_ch.valid      = 1'b1;
        do @(posedge i_clk); while (!cmd_ch.ready);
        predicted = predict_blit(c);
        pending_results.push_back(typed ? want : predicted);
        case (c.op)
            arb_pkg::OP_CLEAR: clears_sent++;
            arb_pkg::OP_BOX:   boxes_sent++;
            arb_pkg::OP_READ:  reads_sent++;
            default:           others_sent++;
        endcase
        burst_left--;
        @(negedge i_clk);
    endtask

    // The weight register may only change while the block is idle, so the
    // sender first stops and waits for every outstanding result word.
    task automatic write_alpha(input logic [ALW-1:0] value);
        cmd_ch.valid = 1'b0;
        burst_left   = 0;
        while (pending_results.size() != 0) @(negedge i_clk);
        cfg_ch.blend_alpha = value;
        cfg_ch.valid       = 1'b1;
        do @(posedge i_clk); while (!cfg_ch.ready);
        alpha_model = value;
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Result taker. It switches between stall patterns at random and,
    // when the sender asks, holds off for one long stretch so that the block
    // backs up and stops taking command words.
    // ------------------------------------------------------------------------
    initial begin : result_taker
        int mode;
        int mode_left;
        int hold_left;
        mode         = 0;
        mode_left    = 0;
        hold_left    = 0;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready = 1'b0;
            end else if (holds_granted != holds_asked) begin
                holds_granted++;
                hold_left    = LONG_HOLD;
                res_ch.ready = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(10, 60);
                end
                mode_left--;
                case (mode)
                    0:       res_ch.ready = 1'b1;
                    1:       res_ch.ready = !res_ch.ready;
                    2:       res_ch.ready = 1'($urandom_range(0, 1));
                    default: res_ch.ready = ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result checker. Each word taken is compared with the oldest prediction.
    // ------------------------------------------------------------------------
    arb_pkg::t_result want_res;

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("%0t: result word with nothing pending: word %h status %b",
                             $realtime, res_ch.pixel_word, res_ch.status);
                end
            end else begin
                want_res = pending_results.pop_front();
                if (res_ch.pixel_word !== want_res.pixel_word ||
                    res_ch.status !== want_res.status) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("%0t: result %0d: word %h status %b, expected %h status %b",
                                 $realtime, results_seen, res_ch.pixel_word,
                                 res_ch.status, want_res.pixel_word, want_res.status);
                    end
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin : main_seq
        t_blit_cmd c;
        t_stim_row r;
        int        phase, k, n;

        i_clk              = 1'b0;
        i_rst_n            = 1'b0;
        cmd_ch.valid       = 1'b0;
        cmd_ch.operation   = arb_pkg::OP_NONE;
        cmd_ch.x_pos       = '0;
        cmd_ch.y_pos       = '0;
        cmd_ch.box_width   = '0;
        cmd_ch.box_height  = '0;
        cmd_ch.box_color   = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.blend_alpha = '0;
        alpha_model        = arb_pkg::ALPHA_RESET;
        for (n = 0; n < arb_pkg::PIXEL_COUNT; n++) frame_model[n] = '0;

        // The framebuffer holds nothing defined until the first clear, so
        // the table opens with one. Typed results are the ones that follow
        // directly: white after the clear, zero with the flag off screen,
        // and the bare colour or the old pixel at the weights zero and one.
        stim_rows.push_back(cmd_row(arb_pkg::OP_CLEAR, 0, 0, 0, 0, '0, 1'b1, '0, 1'b0));
        stim_rows.push_back(cmd_row(arb_pkg::OP_READ, 0, 0, 0, 0, '0, 1'b1,
                                    32'hFFFFFFFF, 1'b0));
        stim_rows.push_back(cmd_row(arb_pkg::OP_READ, 255, 255, 0, 0, '0, 1'b1,
                                    32'hFFFFFFFF, 1'b0));
        stim_rows.push_back(cmd_row(arb_pkg::OP_READ, -1, 0, 0, 0, '0, 1'b1, '0, 1'b1));
        stim_rows.push_back(cmd_row(arb_pkg::OP_READ, 0, 256, 0, 0, '0, 1'b1, '0, 1'b1));
        stim_rows.push_back(cmd_row(arb_pkg::OP_READ, -32768, 32767, 0, 0, '0, 1'b1,
                                    '0, 1'b1));
        stim_rows.push_back(cmd_row(arb_pkg::OP_NONE, 32767, -32768, -1, 32767,
                                    24'hFFFFFF, 1'b1, '0, 1'b0));
        // Default weight after reset, on a white background.
        stim_rows.push_back(cmd_row(arb_pkg::OP_BOX, 10, 10, 4, 3, 24'h123456, 1'b1,
                                    '0, 1'b0));
        stim_rows.push_back(cmd_row(arb_pkg::OP_READ, 11, 11, 0, 0, '0, 1'b0, '0, 1'b0));
        // A box hanging off the left and bottom edges.
        stim_rows.push_back(cmd_row(arb_pkg::OP_BOX, -5, 250, 10, 20, 24'hFF0000, 1'b1,
                                    '0, 1'b0));
        stim_rows.push_back(cmd_row(arb_pkg::OP_READ, 0, 255, 0, 0, '0, 1'b0, '0, 1'b0));
        stim_rows.push_back(cmd_row(arb_pkg::OP_READ, 4, 250, 0, 0, '0, 1'b0, '0, 1'b0));
        stim_rows.push_back(cmd_row(arb_pkg::OP_READ, 5, 250, 0, 0, '0, 1'b0, '0, 1'b0));
        // Boxes wholly off the screen, and an empty one.
        stim_rows.push_back(cmd_row(arb_pkg::OP_BOX, 256, 0, 5, 5, 24'h00FF00, 1'b1,
                                    '0, 1'b0));
        stim_rows.push_back(cmd_row(arb_pkg::OP_BOX, -32768, -32768, 32767, 32767,
                                    24'h0000FF, 1'b1, '0, 1'b0));
        stim_rows.push_back(cmd_row(arb_pkg::OP_BOX, 20, 20, 0, -32768, 24'h00FFFF, 1'b1,
                                    '0, 1'b0));
        // Weight zero: the colour replaces the pixel outright.
        stim_rows.push_back(cfg_row('0));
        stim_rows.push_back(cmd_row(arb_pkg::OP_BOX, 0, 0, 2, 2, 24'hA5C3F0, 1'b1,
                                    '0, 1'b0));
        stim_rows.push_back(cmd_row(arb_pkg::OP_READ, 1, 1, 0, 0, '0, 1'b1,
                                    32'hFFA5C3F0, 1'b0));
        // Weight one: a full-screen box leaves everything as it was.
        stim_rows.push_back(cfg_row(arb_pkg::ALPHA_ONE));
        stim_rows.push_back(cmd_row(arb_pkg::OP_BOX, -100, -100, 32767, 32767,
                                    24'hFFFFFF, 1'b1, '0, 1'b0));
        stim_rows.push_back(cmd_row(arb_pkg::OP_READ, 1, 1, 0, 0, '0, 1'b1,
                                    32'hFFA5C3F0, 1'b0));
        // A weight above one saturates and also keeps the old pixel.
        stim_rows.push_back(cfg_row({ALW{1'b1}}));
        stim_rows.push_back(cmd_row(arb_pkg::OP_BOX, 0, 0, 1, 1, 24'h00FF00, 1'b1,
                                    '0, 1'b0));
        stim_rows.push_back(cmd_row(arb_pkg::OP_READ, 0, 0, 0, 0, '0, 1'b1,
                                    32'hFFA5C3F0, 1'b0));
        stim_rows.push_back(cfg_row(arb_pkg::ALPHA_RESET));
        stim_rows.push_back(cmd_row(arb_pkg::OP_BOX, 32767, 100, 10, 10, 24'h808080,
                                    1'b1, '0, 1'b0));
        stim_rows.push_back(cmd_row(arb_pkg::OP_READ, 10, 10, 0, 0, '0, 1'b0, '0, 1'b0));

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (stim_rows[n]) begin
            r = stim_rows[n];
            if (r.kind == ROW_CFG) write_alpha(r.alpha);
            else                   issue_cmd(r.cmd, r.typed, r.want);
        end

        // Random phases, each at its own weight. The first opens with a long
        // stall of the result side, the second with a clear, the third holds
        // one full-screen box, and the last pauses midway until it drains.
        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0:       write_alpha(ALW'($urandom_range(0, 65536)));
                1:       write_alpha(ALW'($urandom_range(32768, 65535)));
                2:       write_alpha(ALW'($urandom_range(0, 4095)));
                default: write_alpha(ALW'($urandom));
            endcase
            if (phase == 0) holds_asked++;
            for (k = 0; k < PHASE_ITEMS; k++) begin
                c = random_cmd();
                if (phase == 1 && k == 0) begin
                    c.op = arb_pkg::OP_CLEAR;
                end else if (phase == 2 && k == 7) begin
                    c.op         = arb_pkg::OP_BOX;
                    c.x_pos      = '0;
                    c.y_pos      = '0;
                    c.box_width  = CRD'(SW);
                    c.box_height = CRD'(SH);
                end
                if (phase == PHASES - 1 && k == PHASE_ITEMS / 2) begin
                    cmd_ch.valid = 1'b0;
                    burst_left   = 0;
                    while (pending_results.size() != 0) @(negedge i_clk);
                end
                issue_cmd(c, 1'b0, '0);
            end
        end

        cmd_ch.valid = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (END_QUIET) @(negedge i_clk);

        $display("Covered %0d clears, %0d boxes, %0d reads and %0d unused operations",
                 clears_sent, boxes_sent, reads_sent, others_sent);
        $display("over several blend weights; %0d result words checked, %0d mismatches.",
                 results_seen, mismatches);
        if (mismatches == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

@@ alpha_rect_blitter.f @@
+incdir+sv
sv/arb_pkg.sv
sv/arb_if.sv
sv/arb_frame_ram.sv
sv/arb_blend.sv
sv/arb_ctrl.sv
sv/alpha_rect_blitter.sv
sv/arb_checker.sv
dv/tb.sv
